>>> rtl/zrv_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// zrv_pkg
// Shared types and fixed constants of the zero-run visibility decoder.
// ----------------------------------------------------------------------------
package zrv_pkg;

    // Width of the cluster count register as seen on the configuration port.
    localparam int CC_WIDTH = 16;
    // Width used to compare byte counts against the row remainder.
    localparam int CMP_WIDTH = 16;

    localparam logic [7:0] BYTE_ALL_ONES = 8'hFF;
    localparam logic [7:0] BYTE_ZERO     = 8'h00;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] value;
        logic [7:0] repeat_res;
        logic       row_done;
        logic       truncated;
    } t_result;

    // Handshake between the pipeline registers and the decode stage.
    typedef struct packed {
        logic advance;
        logic load_result;
    } t_pipe_ctrl;

endpackage : zrv_pkg
`default_nettype wire

>>> rtl/zrv_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// zrv_in_if
// Channel carrying compressed bytes into the decoder.
// ----------------------------------------------------------------------------
interface zrv_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       final_byte;

    modport source (output valid, output data_byte, output final_byte, input ready);
    modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface : zrv_in_if
`default_nettype wire

>>> rtl/zrv_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// zrv_out_if
// Channel carrying decoded value/repeat results out of the decoder.
// ----------------------------------------------------------------------------
interface zrv_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] value;
    logic [7:0] repeat_res;
    logic       row_done;
    logic       truncated;

    modport source (output valid, output value, output repeat_res, output row_done,
                    output truncated, input ready);
    modport sink   (input valid, input value, input repeat_res, input row_done,
                    input truncated, output ready);
endinterface : zrv_out_if
`default_nettype wire

>>> rtl/zrv_in_reg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// zrv_in_reg
// Input register: holds one compressed word until the decode stage takes it.
// ----------------------------------------------------------------------------
module zrv_in_reg (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    zrv_in_if.sink                i_in,
    input  wire logic             i_advance,
    output logic                  o_valid,
    output zrv_pkg::t_in_item     o_item
);

    logic              r_valid;
    zrv_pkg::t_in_item r_item;
    logic              w_take;

    // A new word may enter when the register is empty or when the held one leaves in the same cycle.
    assign i_in.ready = !r_valid || i_advance;
    assign w_take     = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_item.data_byte  <= i_in.data_byte;
            r_item.final_byte <= i_in.final_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule : zrv_in_reg
`default_nettype wire

>>> rtl/zrv_decode.sv
`default_nettype none
// ----------------------------------------------------------------------------
// zrv_decode
// Row state and decode logic: turns one compressed word into zero or one
// value/repeat result, clipping runs to the row and masking the last byte.
// ----------------------------------------------------------------------------
module zrv_decode #(
    parameter int CW = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [CW-1:0]     i_cfg_count,
    input  wire logic              i_advance,
    input  wire zrv_pkg::t_in_item i_item,
    output logic                   o_res_valid,
    output zrv_pkg::t_result       o_result
);

    localparam int SW = CW - 2;   // row stride width
    localparam int BW = CW - 3;   // bytes written, always below the stride
    localparam int XW = zrv_pkg::CMP_WIDTH;

    logic [CW-1:0] r_count;
    logic [BW-1:0] r_bytes_written;
    logic [BW-1:0] n_bytes_written;
    logic          r_awaiting;
    logic          n_awaiting;

    logic [CW:0]   w_count_plus;
    logic [SW-1:0] w_stride;
    logic [XW-1:0] w_stride_x;
    logic [XW-1:0] w_left_x;
    logic [XW-1:0] w_byte_x;
    logic [XW-1:0] w_run_x;
    logic [XW-1:0] w_rep_x;
    logic [XW-1:0] w_sum_x;
    logic [2:0]    w_slack;
    logic [7:0]    w_mask;
    logic          w_done;
    logic          w_zero_count;
    logic [7:0]    w_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= CW'(1);
        end else if (i_cfg_we) begin
            r_count <= i_cfg_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_written <= '0;
            r_awaiting      <= 1'b0;
        end else if (i_cfg_we) begin
            r_bytes_written <= '0;
            r_awaiting      <= 1'b0;
        end else if (i_advance) begin
            r_bytes_written <= n_bytes_written;
            r_awaiting      <= n_awaiting;
        end
    end

    // Row stride is ceil(count / 8) bytes.
    assign w_count_plus = {1'b0, r_count} + (CW+1)'(7);
    assign w_stride     = w_count_plus[CW:3];
    assign w_zero_count = (r_count == '0);

    assign w_stride_x = XW'(w_stride);
    assign w_left_x   = w_stride_x - XW'(r_bytes_written);
    assign w_byte_x   = XW'(i_item.data_byte);
    assign w_run_x    = (w_byte_x < w_left_x) ? w_byte_x : w_left_x;
    assign w_rep_x    = r_awaiting ? w_run_x : XW'(1);
    assign w_sum_x    = XW'(r_bytes_written) + w_rep_x;
    assign w_done     = (w_sum_x == w_stride_x);

    // Bits of the last byte beyond the cluster count are cleared.
    assign w_slack = 3'd0 - r_count[2:0];
    assign w_mask  = zrv_pkg::BYTE_ALL_ONES >> w_slack;
    assign w_value = r_awaiting ? zrv_pkg::BYTE_ZERO : i_item.data_byte;

    always_comb begin
        n_bytes_written     = '0;
        n_awaiting          = 1'b0;
        o_res_valid         = 1'b0;
        o_result.value      = zrv_pkg::BYTE_ALL_ONES;
        o_result.repeat_res = zrv_pkg::BYTE_ZERO;
        o_result.row_done   = 1'b1;
        o_result.truncated  = 1'b1;
        if (w_zero_count) begin
            // An empty row swallows every word.
            o_res_valid = 1'b0;
        end else if (!r_awaiting && (i_item.data_byte == zrv_pkg::BYTE_ZERO)) begin
            if (i_item.final_byte) begin
                o_res_valid = 1'b1;
            end else begin
                n_bytes_written = r_bytes_written;
                n_awaiting      = 1'b1;
            end
        end else if (w_done) begin
            o_res_valid         = 1'b1;
            o_result.value      = w_value & w_mask;
            o_result.repeat_res = w_rep_x[7:0];
            o_result.truncated  = 1'b0;
        end else if (i_item.final_byte) begin
            o_res_valid = 1'b1;
        end else begin
            n_bytes_written     = w_sum_x[BW-1:0];
            o_res_valid         = 1'b1;
            o_result.value      = w_value;
            o_result.repeat_res = w_rep_x[7:0];
            o_result.row_done   = 1'b0;
            o_result.truncated  = 1'b0;
        end
    end

    // The count of bytes already in the row stays below the stride.
    a_bytes_below_stride: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_zero_count |-> (XW'(r_bytes_written) < w_stride_x))
        else $error("bytes written reached the row stride");

    // A configuration write leaves a fresh row behind it.
    a_cfg_clears_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> (r_bytes_written == '0) && !r_awaiting)
        else $error("row state not cleared by configuration write");

    // A row that ends normally always has at least one byte in its last result.
    a_done_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_advance && o_res_valid && o_result.row_done && !o_result.truncated)
            |-> (o_result.repeat_res != zrv_pkg::BYTE_ZERO))
        else $error("row completed by an empty result");

    // A truncation result carries the all-ones marker and ends the row.
    a_trunc_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_advance && o_res_valid && o_result.truncated)
            |=> (r_bytes_written == '0) && !r_awaiting)
        else $error("truncation left row state behind");

endmodule : zrv_decode
`default_nettype wire

>>> rtl/zrv_out_reg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// zrv_out_reg
// Result register: holds a decoded word until the consumer takes it.
// ----------------------------------------------------------------------------
module zrv_out_reg (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire zrv_pkg::t_pipe_ctrl i_ctrl,
    input  wire zrv_pkg::t_result    i_result,
    output logic                     o_free,
    zrv_out_if.source                o_out
);

    logic             r_valid;
    zrv_pkg::t_result r_result;

    assign o_free = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctrl.load_result) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_result) begin
            r_result <= i_result;
        end
    end

    assign o_out.valid      = r_valid;
    assign o_out.value      = r_result.value;
    assign o_out.repeat_res = r_result.repeat_res;
    assign o_out.row_done   = r_result.row_done;
    assign o_out.truncated  = r_result.truncated;

endmodule : zrv_out_reg
`default_nettype wire

>>> rtl/zero_run_visibility_decoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// zero_run_visibility_decoder
// Decodes a zero-run compressed visibility row into value/repeat words.
// ----------------------------------------------------------------------------
//   channel   dir  handshake      payload
//   i_in      in   valid/ready    data_byte[7:0], final_byte
//   o_out     out  valid/ready    value[7:0], repeat_res[7:0], row_done, truncated
//   cfg       in   i_cfg_we       i_cfg_data[15:0] (cluster count)
//
// One compressed word is accepted every cycle while the result register stays free;
// each word waits in the input register, and its result is loaded into the
// result register for the consumer. A zero word that opens a run gives no result.
// The decode stage updates its byte counter and run flag as each word advances.
// Reset is synchronous and active low; the cluster count resets to one.
// A stalled consumer holds the result register, and the input register
// fills behind it before i_in.ready drops.
// ----------------------------------------------------------------------------
module zero_run_visibility_decoder #(
    parameter int CLUSTER_BITS = 16
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [zrv_pkg::CC_WIDTH-1:0]   i_cfg_data,
    zrv_in_if.sink                              i_in,
    zrv_out_if.source                           o_out
);

    localparam int CW = (CLUSTER_BITS < zrv_pkg::CC_WIDTH) ? CLUSTER_BITS
                                                          : zrv_pkg::CC_WIDTH;

    logic                in_valid;
    zrv_pkg::t_in_item   in_item;
    logic                res_valid;
    zrv_pkg::t_result    result;
    logic                out_free;
    zrv_pkg::t_pipe_ctrl ctrl;

    assign ctrl.advance     = in_valid && out_free;
    assign ctrl.load_result = ctrl.advance && res_valid;

    zrv_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_advance (ctrl.advance),
        .o_valid   (in_valid),
        .o_item    (in_item)
    );

    zrv_decode #(
        .CW (CW)
    ) u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_count (i_cfg_data[CW-1:0]),
        .i_advance   (ctrl.advance),
        .i_item      (in_item),
        .o_res_valid (res_valid),
        .o_result    (result)
    );

    zrv_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (ctrl),
        .i_result (result),
        .o_free   (out_free),
        .o_out    (o_out)
    );

endmodule : zero_run_visibility_decoder
`default_nettype wire

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the zero-run visibility decoder. A queue of
// compressed words feeds a clocked driver; a clocked monitor compares every
// decoded word against a row decoder kept in the bench, field by field.
// Phases sweep the cluster count, the idling of both sides and a long
// consumer stall that backs the decoder up into its input.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int          CLUSTER_BITS  = 16;
    localparam int unsigned CLUSTER_MASK  = (1 << CLUSTER_BITS) - 1;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          HOLD_CYCLES   = 80;

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_mode;

    logic                         clk;
    logic                         rst_n;
    logic                         cfg_we;
    logic [zrv_pkg::CC_WIDTH-1:0] cfg_data;
    logic                         hold_start;
    int unsigned                  hold_left;
    t_idle_mode                   idle_mode;
    int unsigned                  error_count;

    zrv_in_if  in_bus ();
    zrv_out_if out_bus ();

    zero_run_visibility_decoder #(
        .CLUSTER_BITS(CLUSTER_BITS)
    ) i_dut (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_cfg_we  (cfg_we),
        .i_cfg_data(cfg_data),
        .i_in      (in_bus),
        .o_out     (out_bus)
    );

    // Bench copy of the decoder state.
    int unsigned row_clusters;
    int unsigned row_bytes_done;
    bit          run_count_due;

    zrv_pkg::t_in_item compressed_words[$];
    zrv_pkg::t_result  decoded_runs_due[$];

    always begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic bit chance(input int unsigned pct);
        return $urandom_range(99) < pct;
    endfunction

    function automatic int unsigned sender_gap_pct();
        case (idle_mode)
            IDLE_SENDER: return 58;
            IDLE_BOTH:   return 6;
            default:     return 0;
        endcase
    endfunction

    function automatic int unsigned receiver_stall_pct();
        case (idle_mode)
            IDLE_RECEIVER: return 58;
            IDLE_BOTH:     return 6;
            default:       return 0;
        endcase
    endfunction

    function automatic void push_decoded(input logic [7:0] value, input logic [7:0] count,
                                         input logic done, input logic trunc);
        zrv_pkg::t_result r;
        r.value      = value;
        r.repeat_res = count;
        r.row_done   = done;
        r.truncated  = trunc;
        decoded_runs_due = {decoded_runs_due, r};
    endfunction

    function automatic void clear_row_state();
        row_bytes_done = 0;
        run_count_due  = 1'b0;
    endfunction

    // Advances the row decoder by one compressed word.
    function automatic void decode_compressed_word(input zrv_pkg::t_in_item w);
        int unsigned stride;
        int unsigned left;
        int unsigned value;
        int unsigned count;
        int unsigned slack;

        stride = (row_clusters + 7) / 8;
        if (stride == 0) begin
            clear_row_state();
            return;
        end
        if (row_bytes_done >= stride) begin
            row_bytes_done = 0;
        end
        left = stride - row_bytes_done;

        if (!run_count_due) begin
            if (w.data_byte != zrv_pkg::BYTE_ZERO) begin
                value = 32'(w.data_byte);
                count = 1;
            end else if (w.final_byte) begin
                clear_row_state();
                push_decoded(zrv_pkg::BYTE_ALL_ONES, 8'd0, 1'b1, 1'b1);
                return;
            end else begin
                run_count_due = 1'b1;
                return;
            end
        end else begin
            run_count_due = 1'b0;
            value = 0;
            count = (32'(w.data_byte) < left) ? 32'(w.data_byte) : left;
        end

        row_bytes_done += count;
        if (row_bytes_done == stride) begin
            // Clear the bits of the closing byte that lie past the last cluster.
            slack = stride * 8 - row_clusters;
            value = value & (32'hFF >> (slack & 7));
            clear_row_state();
            push_decoded(value[7:0], count[7:0], 1'b1, 1'b0);
        end else if (w.final_byte) begin
            clear_row_state();
            push_decoded(zrv_pkg::BYTE_ALL_ONES, 8'd0, 1'b1, 1'b1);
        end else begin
            push_decoded(value[7:0], count[7:0], 1'b0, 1'b0);
        end
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            error_count++;
        end
    endfunction

    // Driver: a word stays offered until it is taken.
    always @(posedge clk) begin : drive_words
        bit fire;
        fire = in_bus.valid && in_bus.ready;
        if (!rst_n) begin
            in_bus.valid <= 1'b0;
        end else begin
            if (fire) begin
                decode_compressed_word(compressed_words.pop_front());
            end
            if (fire || !in_bus.valid) begin
                if (compressed_words.size() != 0 && !chance(sender_gap_pct())) begin
                    in_bus.valid      <= 1'b1;
                    in_bus.data_byte  <= compressed_words[0].data_byte;
                    in_bus.final_byte <= compressed_words[0].final_byte;
                end else begin
                    in_bus.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk) begin : count_hold
        if (hold_start) begin
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Monitor: every decoded word must match the oldest one due.
    always @(posedge clk) begin : watch_results
        zrv_pkg::t_result want;
        if (!rst_n) begin
            out_bus.ready <= 1'b0;
        end else begin
            if (out_bus.valid && out_bus.ready) begin
                if (decoded_runs_due.size() == 0) begin
                    $display("%0t: unexpected word, expected none, actual %0h/%0h/%0b/%0b",
                             $time, out_bus.value, out_bus.repeat_res,
                             out_bus.row_done, out_bus.truncated);
                    error_count++;
                end else begin
                    want = decoded_runs_due.pop_front();
                    check_field("value", 32'(want.value), 32'(out_bus.value));
                    check_field("repeat_res", 32'(want.repeat_res), 32'(out_bus.repeat_res));
                    check_field("row_done", 32'(want.row_done), 32'(out_bus.row_done));
                    check_field("truncated", 32'(want.truncated), 32'(out_bus.truncated));
                end
            end
            out_bus.ready <= !hold_start && hold_left == 0 && !chance(receiver_stall_pct());
        end
    end

    task automatic push_word(input logic [7:0] data, input logic fin);
        zrv_pkg::t_in_item w;
        w.data_byte  = data;
        w.final_byte = fin;
        compressed_words = {compressed_words, w};
    endtask

    task automatic wait_drained();
        while (compressed_words.size() != 0 || decoded_runs_due.size() != 0) begin
            @(posedge clk);
        end
        // A zero word yields nothing and may still be in the pipeline.
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_clusters(input logic [zrv_pkg::CC_WIDTH-1:0] clusters);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= clusters;
        row_clusters = 32'(clusters) & CLUSTER_MASK;
        clear_row_state();
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Mostly well-formed rows of literals and runs, with some noise mixed in.
    task automatic build_rows(input int unsigned n_words);
        int unsigned stride;
        int unsigned left;
        int unsigned made;
        int unsigned cnt;
        int unsigned cap;
        logic        fin;
        logic [7:0]  lit;

        stride = (row_clusters + 7) / 8;
        left   = stride;
        made   = 0;
        while (made < n_words) begin
            if (stride == 0 || chance(8)) begin
                push_word(8'($urandom_range(255)), chance(30));
                made++;
                left = stride;
            end else if (chance(left > 64 ? 80 : 45)) begin
                fin = chance(3);
                push_word(zrv_pkg::BYTE_ZERO, fin);
                made++;
                if (fin) begin
                    left = stride;
                    continue;
                end
                cap = (left < 255) ? left : 255;
                case ($urandom_range(3))
                    0:       cnt = 0;
                    1:       cnt = $urandom_range(cap, 1);
                    2:       cnt = cap;
                    default: cnt = $urandom_range(255);
                endcase
                fin = chance(4);
                push_word(cnt[7:0], fin);
                made++;
                left -= (cnt < left) ? cnt : left;
                if (left == 0 || fin) begin
                    left = stride;
                end
            end else begin
                lit = 8'($urandom_range(255, 1));
                fin = chance(left == 1 ? 15 : 3);
                push_word(lit, fin);
                made++;
                left--;
                if (left == 0 || fin) begin
                    left = stride;
                end
            end
        end
    endtask

    task automatic run_phase(input logic [zrv_pkg::CC_WIDTH-1:0] clusters,
                             input int unsigned n_words,
                             input t_idle_mode mode, input bit squeeze);
        wait_drained();
        write_clusters(clusters);
        @(negedge clk);
        idle_mode = mode;
        build_rows(n_words);
        if (squeeze) begin
            // Stall the consumer long enough for the input side to back up.
            while (compressed_words.size() + 3 > n_words) begin
                @(posedge clk);
            end
            hold_start <= 1'b1;
            @(posedge clk);
            hold_start <= 1'b0;
        end
    endtask

    initial begin
        logic [zrv_pkg::CC_WIDTH-1:0] sweep[10];

        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_data          = '0;
        hold_start        = 1'b0;
        hold_left         = 0;
        idle_mode         = IDLE_NONE;
        error_count       = 0;
        in_bus.valid      = 1'b0;
        in_bus.data_byte  = '0;
        in_bus.final_byte = 1'b0;
        out_bus.ready     = 1'b0;
        row_clusters      = 1;
        clear_row_state();

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // One-byte row with the reset cluster count: masking, empty and clipped
        // runs, and a zero word that is also the source's last.
        @(negedge clk);
        push_word(8'hFF, 1'b0);
        push_word(8'h80, 1'b0);
        push_word(zrv_pkg::BYTE_ZERO, 1'b0);
        push_word(8'h00, 1'b0);
        push_word(zrv_pkg::BYTE_ZERO, 1'b0);
        push_word(8'hFF, 1'b0);
        push_word(zrv_pkg::BYTE_ZERO, 1'b1);

        // Two-byte row of 13 clusters: partial rows cut off by a final word,
        // and a final word that exactly closes the row.
        wait_drained();
        write_clusters(16'd13);
        @(negedge clk);
        push_word(8'h01, 1'b0);
        push_word(8'hFF, 1'b0);
        push_word(zrv_pkg::BYTE_ZERO, 1'b0);
        push_word(8'h05, 1'b0);
        push_word(8'h7F, 1'b1);
        push_word(zrv_pkg::BYTE_ZERO, 1'b0);
        push_word(8'h01, 1'b1);
        push_word(zrv_pkg::BYTE_ZERO, 1'b0);
        push_word(8'h01, 1'b0);
        push_word(8'hAA, 1'b1);

        // With no clusters every word is dropped.
        wait_drained();
        write_clusters(16'd0);
        @(negedge clk);
        push_word(8'h5A, 1'b0);
        push_word(zrv_pkg::BYTE_ZERO, 1'b0);
        push_word(zrv_pkg::BYTE_ZERO, 1'b1);

        sweep[0] = 16'd8;
        sweep[1] = 16'd9;
        sweep[2] = 16'hFFFF;
        sweep[3] = 16'd24;
        sweep[4] = 16'd100;
        sweep[5] = 16'($urandom_range(600, 1));
        sweep[6] = 16'd1;
        sweep[7] = 16'd17;
        sweep[8] = 16'($urandom_range(16'hFFFF, 1));
        sweep[9] = 16'd2;
        for (int i = 0; i < 10; i++) begin
            run_phase(sweep[i], 48, t_idle_mode'(i % 4), i == 0 || i == 6);
        end
        run_phase(16'd0, 15, IDLE_BOTH, 1'b0);
        run_phase(16'd3, 30, IDLE_NONE, 1'b0);

        wait_drained();
        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #1_600_000;
        $display("status: fail");
        $finish;
    end

endmodule : tb_top

>>> zero_run_visibility_decoder.f
rtl/zrv_pkg.sv
rtl/zrv_in_if.sv
rtl/zrv_out_if.sv
rtl/zrv_in_reg.sv
rtl/zrv_decode.sv
rtl/zrv_out_reg.sv
rtl/zero_run_visibility_decoder.sv
verif/tb_top.sv
